FILE: design/assert_macros.svh
// assertion macros shared by the space map decoder modules
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SMED_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("space map decoder check failed");

// antecedent implies consequent in the next cycle
`define SMED_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("space map decoder check failed");

`endif

FILE: design/smed_pkg.sv
// shared types and constants for the space map entry decoder
// no dependencies
package smed_pkg;

    localparam int SMED_QDEPTH = 2;

    localparam int WORD_W = 64;
    localparam int OFF_W  = 63;
    localparam int RUN_W  = 37;
    localparam int DEV_W  = 24;
    localparam int TXG_W  = 50;
    localparam int SH_W   = 6;

    // register indexes of the configuration port
    localparam logic CFG_BASE_OFFSET  = 1'b0;
    localparam logic CFG_SHIFT_AMOUNT = 1'b1;

    localparam logic [SH_W-1:0] SHIFT_RESET = 6'd9;

    // top two bits of a debug word and of a pair head
    localparam logic [1:0] WTYPE_DEBUG = 2'b10;
    localparam logic [1:0] WTYPE_PAIR  = 2'b11;

    // decoded entry, unshifted, handed from front to back
    typedef struct packed {
        logic             alloc;
        logic [OFF_W-1:0] offset;
        logic [RUN_W-1:0] run;
        logic [DEV_W-1:0] device;
        logic [TXG_W-1:0] txg;
        logic             status;
    } t_smed_cmd;

    // queue handshake seen by the front end and the back end
    typedef struct packed {
        logic empty;
        logic full;
    } t_smed_qstat;

endpackage

FILE: design/smed_front.sv
// front end: accepts space map words, tracks pair and txg state, emits entries
// depends on smed_pkg and assert_macros.svh
`include "assert_macros.svh"

module smed_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [smed_pkg::WORD_W-1:0]         i_map_word,
    input  logic                                i_final_word,
    input  smed_pkg::t_smed_qstat               i_qstat,
    output logic                                o_push,
    output smed_pkg::t_smed_cmd                 o_cmd
);
    import smed_pkg::*;

    logic             r_pair_pending, n_pair_pending;
    logic [RUN_W-1:0] r_pending_run, n_pending_run;
    logic [DEV_W-1:0] r_pending_dev, n_pending_dev;
    logic [TXG_W-1:0] r_txg, n_txg;

    logic      accept;
    logic      has_result;
    t_smed_cmd cmd;

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        cmd            = '0;
        cmd.txg        = r_txg;
        has_result     = 1'b0;
        n_pair_pending = r_pair_pending;
        n_pending_run  = r_pending_run;
        n_pending_dev  = r_pending_dev;
        n_txg          = r_txg;
        if (r_pair_pending) begin
            // second word of a pair, whatever its top bits
            cmd.alloc      = !i_map_word[63];
            cmd.offset     = i_map_word[OFF_W-1:0];
            cmd.run        = r_pending_run;
            cmd.device     = r_pending_dev;
            has_result     = 1'b1;
            n_pair_pending = 1'b0;
            n_pending_run  = '0;
            n_pending_dev  = '0;
        end else begin
            case (i_map_word[63:62])
                WTYPE_DEBUG: begin
                    if (i_map_word[TXG_W-1:0] != '0) begin
                        n_txg = i_map_word[TXG_W-1:0];
                    end
                end
                WTYPE_PAIR: begin
                    if (i_final_word) begin
                        cmd.status = 1'b1;
                        has_result = 1'b1;
                    end else begin
                        n_pending_run  = {1'b0, i_map_word[59:24]} + RUN_W'(1);
                        n_pending_dev  = i_map_word[DEV_W-1:0];
                        n_pair_pending = 1'b1;
                    end
                end
                default: begin
                    cmd.alloc  = !i_map_word[15];
                    cmd.offset = OFF_W'(i_map_word[62:16]);
                    cmd.run    = RUN_W'({1'b0, i_map_word[14:0]}) + RUN_W'(1);
                    has_result = 1'b1;
                end
            endcase
        end
        // end of map starts a fresh map
        if (i_final_word) begin
            n_pair_pending = 1'b0;
            n_pending_run  = '0;
            n_pending_dev  = '0;
            n_txg          = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_pending <= 1'b0;
            r_pending_run  <= '0;
            r_pending_dev  <= '0;
            r_txg          <= '0;
        end else if (accept) begin
            r_pair_pending <= n_pair_pending;
            r_pending_run  <= n_pending_run;
            r_pending_dev  <= n_pending_dev;
            r_txg          <= n_txg;
        end
    end

    assign o_push = accept && has_result;
    assign o_cmd  = cmd;

    `SMED_ASSERT_NXT(a_final_clears, i_clk, i_rst_n, accept && i_final_word,
        !r_pair_pending && r_txg == '0)
    `SMED_ASSERT_IMP(a_push_not_full, i_clk, i_rst_n, o_push, !i_qstat.full)

endmodule

FILE: design/smed_queue.sv
// short entry queue between front and back end
// depends on smed_pkg and assert_macros.svh
`include "assert_macros.svh"

module smed_queue #(
    parameter int DEPTH = smed_pkg::SMED_QDEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  smed_pkg::t_smed_cmd   i_cmd,
    input  logic                  i_pop,
    output smed_pkg::t_smed_cmd   o_head,
    output smed_pkg::t_smed_qstat o_qstat
);
    import smed_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_smed_cmd        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_head        = r_mem[r_rd_ptr];
    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == CNT_W'(DEPTH));

    `SMED_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `SMED_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

FILE: design/smed_back.sv
// back end: shifts offset and run, adds the base offset, holds the result
// depends on smed_pkg and assert_macros.svh
`include "assert_macros.svh"

module smed_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  smed_pkg::t_smed_cmd          i_head,
    input  smed_pkg::t_smed_qstat        i_qstat,
    output logic                         o_pop,
    input  logic [smed_pkg::WORD_W-1:0]  i_base_offset,
    input  logic [smed_pkg::SH_W-1:0]    i_shift_amount,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_allocated,
    output logic [smed_pkg::WORD_W-1:0]  o_range_start,
    output logic [smed_pkg::WORD_W-1:0]  o_range_length,
    output logic [smed_pkg::DEV_W-1:0]   o_device_id,
    output logic [smed_pkg::TXG_W-1:0]   o_group_txg,
    output logic                         o_status
);
    import smed_pkg::*;

    // stage one: shifted values
    logic              r_s1_vld;
    logic              r_s1_alloc;
    logic [WORD_W-1:0] r_s1_off;
    logic [WORD_W-1:0] r_s1_len;
    logic [DEV_W-1:0]  r_s1_dev;
    logic [TXG_W-1:0]  r_s1_txg;
    logic              r_s1_status;

    // output register
    logic              r_out_vld;
    logic              r_out_alloc;
    logic [WORD_W-1:0] r_out_start;
    logic [WORD_W-1:0] r_out_len;
    logic [DEV_W-1:0]  r_out_dev;
    logic [TXG_W-1:0]  r_out_txg;
    logic              r_out_status;

    logic              out_en;
    logic              s1_en;

    assign out_en = !r_out_vld || i_ready;
    assign s1_en  = !r_s1_vld || out_en;
    assign o_pop  = !i_qstat.empty && s1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_en) begin
                r_s1_vld <= o_pop;
            end
            if (out_en) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_alloc  <= i_head.alloc;
            r_s1_off    <= {1'b0, i_head.offset} << i_shift_amount;
            r_s1_len    <= WORD_W'(i_head.run) << i_shift_amount;
            r_s1_dev    <= i_head.device;
            r_s1_txg    <= i_head.txg;
            r_s1_status <= i_head.status;
        end
        if (out_en && r_s1_vld) begin
            r_out_alloc  <= r_s1_alloc;
            // a truncated pair reports a zero start
            r_out_start  <= r_s1_status ? '0 : i_base_offset + r_s1_off;
            r_out_len    <= r_s1_len;
            r_out_dev    <= r_s1_dev;
            r_out_txg    <= r_s1_txg;
            r_out_status <= r_s1_status;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_allocated    = r_out_alloc;
    assign o_range_start  = r_out_start;
    assign o_range_length = r_out_len;
    assign o_device_id    = r_out_dev;
    assign o_group_txg    = r_out_txg;
    assign o_status       = r_out_status;

    `SMED_ASSERT_NXT(a_s1_held, i_clk, i_rst_n, r_s1_vld && r_out_vld && !i_ready, r_s1_vld)

endmodule

FILE: design/space_map_entry_decoder.sv
// top level of the space map entry decoder: config registers, front, queue, back
// depends on smed_pkg, smed_front, smed_queue and smed_back
//
//   channel   signals                                 direction
//   word in   i_valid / o_ready, i_map_word, i_final_word   in
//   entry out o_valid / i_ready, o_allocated ... o_status   out
//   config    i_cfg_we, i_cfg_idx, i_cfg_data               in
//
// one word per cycle sustained while o_ready is high; a word that yields an entry is queued at
// its transfer and then passes the shift stage, then the add stage that loads the output register
// debug words and a pair head that is not final yield no entry
// o_ready drops only when the entry queue is full; the back end drains it
// whenever its shift stage or the output register is free, or the output register is being taken
// synchronous active-low reset clears pair and txg state and sets shift to 9
module space_map_entry_decoder #(
    parameter int QDEPTH = smed_pkg::SMED_QDEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [smed_pkg::WORD_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [smed_pkg::WORD_W-1:0]   i_map_word,
    input  logic                          i_final_word,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_allocated,
    output logic [smed_pkg::WORD_W-1:0]   o_range_start,
    output logic [smed_pkg::WORD_W-1:0]   o_range_length,
    output logic [smed_pkg::DEV_W-1:0]    o_device_id,
    output logic [smed_pkg::TXG_W-1:0]    o_group_txg,
    output logic                          o_status
);
    import smed_pkg::*;

    logic [WORD_W-1:0] r_base_offset;
    logic [SH_W-1:0]   r_shift_amount;

    logic        push;
    logic        pop;
    t_smed_cmd   cmd;
    t_smed_cmd   head;
    t_smed_qstat qstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_offset  <= '0;
            r_shift_amount <= SHIFT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_OFFSET:  r_base_offset  <= i_cfg_data;
                CFG_SHIFT_AMOUNT: r_shift_amount <= i_cfg_data[SH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    smed_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_map_word   (i_map_word),
        .i_final_word (i_final_word),
        .i_qstat      (qstat),
        .o_push       (push),
        .o_cmd        (cmd)
    );

    smed_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    smed_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_qstat        (qstat),
        .o_pop          (pop),
        .i_base_offset  (r_base_offset),
        .i_shift_amount (r_shift_amount),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_allocated    (o_allocated),
        .o_range_start  (o_range_start),
        .o_range_length (o_range_length),
        .o_device_id    (o_device_id),
        .o_group_txg    (o_group_txg),
        .o_status       (o_status)
    );

endmodule

FILE: tb/space_map_checker.sv
// checker for the space map entry decoder: watches the word, entry and config ports
// keeps its own decoder state, predicts every entry and compares field by field
// depends on smed_pkg
module space_map_checker
    import smed_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [WORD_W-1:0] i_cfg_data,
    input  logic              i_word_valid,
    input  logic              i_word_ready,
    input  logic [WORD_W-1:0] i_map_word,
    input  logic              i_final_word,
    input  logic              i_entry_valid,
    input  logic              i_entry_ready,
    input  logic              i_allocated,
    input  logic [WORD_W-1:0] i_range_start,
    input  logic [WORD_W-1:0] i_range_length,
    input  logic [DEV_W-1:0]  i_device_id,
    input  logic [TXG_W-1:0]  i_group_txg,
    input  logic              i_status,
    output int                o_error_count,
    output int                o_pending_entries
);

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_TRUNCATED = 1'b1;
    localparam int   PRINT_CAP        = 40;

    typedef struct packed {
        logic              alloc;
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] length;
        logic [DEV_W-1:0]  device;
        logic [TXG_W-1:0]  txg;
        logic              status;
    } range_rec_t;

    range_rec_t expected_ranges[$];

    logic [WORD_W-1:0] base_reg;
    logic [SH_W-1:0]   shift_reg;
    logic              pair_open;
    logic [RUN_W-1:0]  held_run;
    logic [DEV_W-1:0]  held_device;
    logic [TXG_W-1:0]  txg_reg;

    initial begin
        o_error_count = 0;
        o_pending_entries = 0;
    end

    task report_mismatch(input string what, input logic [WORD_W-1:0] got,
                         input logic [WORD_W-1:0] want);
        o_error_count = o_error_count + 1;
        if (o_error_count <= PRINT_CAP)
            $display("mismatch in %s at %0t: got %0h, expected %0h", what, $time, got, want);
    endtask

    task clear_map;
        pair_open = 1'b0;
        held_run = '0;
        held_device = '0;
        txg_reg = '0;
    endtask

    task decode_word(input logic [WORD_W-1:0] w, input logic fin);
        range_rec_t rec;
        logic [WORD_W-1:0] off;
        rec = '0;
        rec.status = STATUS_OK;
        if (pair_open) begin
            // the word after a pair head is always its second word
            off = {1'b0, w[62:0]};
            rec.alloc = ~w[63];
            rec.start = base_reg + (off << shift_reg);
            rec.length = {{(WORD_W-RUN_W){1'b0}}, held_run} << shift_reg;
            rec.device = held_device;
            rec.txg = txg_reg;
            expected_ranges.push_back(rec);
            pair_open = 1'b0;
            held_run = '0;
            held_device = '0;
        end else if (w[63:62] == WTYPE_DEBUG) begin
            if (w[TXG_W-1:0] != '0)
                txg_reg = w[TXG_W-1:0];
        end else if (w[63:62] == WTYPE_PAIR) begin
            if (fin) begin
                rec.txg = txg_reg;
                rec.status = STATUS_TRUNCATED;
                expected_ranges.push_back(rec);
            end else begin
                held_run = {1'b0, w[59:24]} + 37'd1;
                held_device = w[DEV_W-1:0];
                pair_open = 1'b1;
            end
        end else begin
            off = {17'd0, w[62:16]};
            rec.alloc = ~w[15];
            rec.start = base_reg + (off << shift_reg);
            rec.length = {48'd0, {1'b0, w[14:0]} + 16'd1} << shift_reg;
            rec.txg = txg_reg;
            expected_ranges.push_back(rec);
        end
        if (fin)
            clear_map();
    endtask

    task check_entry;
        range_rec_t want;
        if (expected_ranges.size() == 0) begin
            report_mismatch("entry transfer with nothing expected", 1, 0);
        end else begin
            want = expected_ranges.pop_front();
            if (i_allocated !== want.alloc)
                report_mismatch("allocated", i_allocated, want.alloc);
            if (i_range_start !== want.start)
                report_mismatch("range_start", i_range_start, want.start);
            if (i_range_length !== want.length)
                report_mismatch("range_length", i_range_length, want.length);
            if (i_device_id !== want.device)
                report_mismatch("device_id", i_device_id, want.device);
            if (i_group_txg !== want.txg)
                report_mismatch("group_txg", i_group_txg, want.txg);
            if (i_status !== want.status)
                report_mismatch("status", i_status, want.status);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_reg = '0;
            shift_reg = SHIFT_RESET;
            clear_map();
            expected_ranges.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BASE_OFFSET)
                    base_reg = i_cfg_data;
                else
                    shift_reg = i_cfg_data[SH_W-1:0];
            end
            // compare before predicting so a same-edge word cannot satisfy an entry
            if (i_entry_valid && i_entry_ready)
                check_entry();
            if (i_word_valid && i_word_ready)
                decode_word(i_map_word, i_final_word);
        end
        o_pending_entries <= expected_ranges.size();
    end

endmodule

FILE: tb/testbench.sv
// top of the space map entry decoder testbench: clock, reset, word stimulus, config
// phases and entry-side stalls; depends on smed_pkg, space_map_entry_decoder and
// space_map_checker
module testbench;
    import smed_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [WORD_W-1:0] i_cfg_data;
    logic              i_valid;
    logic              o_ready;
    logic [WORD_W-1:0] i_map_word;
    logic              i_final_word;
    logic              o_valid;
    logic              i_ready;
    logic              o_allocated;
    logic [WORD_W-1:0] o_range_start;
    logic [WORD_W-1:0] o_range_length;
    logic [DEV_W-1:0]  o_device_id;
    logic [TXG_W-1:0]  o_group_txg;
    logic              o_status;

    int error_total;
    int pending_entries;
    int cycle_count = 0;
    int words_sent = 0;
    int in_gap_pct = 0;
    int out_stall_pct = 0;
    int stall_left = 0;

    space_map_entry_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_map_word    (i_map_word),
        .i_final_word  (i_final_word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_allocated   (o_allocated),
        .o_range_start (o_range_start),
        .o_range_length(o_range_length),
        .o_device_id   (o_device_id),
        .o_group_txg   (o_group_txg),
        .o_status      (o_status)
    );

    space_map_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_word_valid     (i_valid),
        .i_word_ready     (o_ready),
        .i_map_word       (i_map_word),
        .i_final_word     (i_final_word),
        .i_entry_valid    (o_valid),
        .i_entry_ready    (i_ready),
        .i_allocated      (o_allocated),
        .i_range_start    (o_range_start),
        .i_range_length   (o_range_length),
        .i_device_id      (o_device_id),
        .i_group_txg      (o_group_txg),
        .i_status         (o_status),
        .o_error_count    (error_total),
        .o_pending_entries(pending_entries)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // entry side back-pressure in random bursts, started with probability out_stall_pct percent
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_ready <= 1'b0;
        end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
            stall_left = $urandom_range(1, 7) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [WORD_W-1:0] debug_word();
        logic [TXG_W-1:0] txg;
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            txg = '0;
        else if (pick == 1)
            txg = TXG_W'($urandom_range(1, 255));
        else
            txg = TXG_W'(rand_word());
        return {WTYPE_DEBUG, 12'($urandom), txg};
    endfunction

    function automatic logic [WORD_W-1:0] single_word();
        logic [46:0] off;
        logic [14:0] run;
        off = ($urandom_range(0, 1) == 0) ? 47'($urandom_range(0, 4095)) : 47'(rand_word());
        case ($urandom_range(0, 3))
            0:       run = '0;
            1:       run = '1;
            default: run = 15'($urandom);
        endcase
        return {1'b0, off, 1'($urandom), run};
    endfunction

    function automatic logic [WORD_W-1:0] pair_head();
        logic [35:0] run;
        run = ($urandom_range(0, 1) == 0) ? 36'($urandom_range(0, 1023)) : 36'(rand_word());
        return {WTYPE_PAIR, 2'($urandom), run, 24'($urandom)};
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] w, input logic fin);
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_map_word <= w;
        i_final_word <= fin;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    // one map: mostly well-formed entries, some noise words and cut-off pairs
    task automatic send_map();
        int n;
        int kind;
        logic last_one;
        n = $urandom_range(1, 16);
        for (int k = 0; k < n; k++) begin
            last_one = (k == n - 1);
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                send_word(debug_word(), last_one);
            end else if (kind < 55) begin
                send_word(single_word(), last_one);
            end else if (kind < 88) begin
                send_word(pair_head(), 1'b0);
                send_word(rand_word(), last_one);
            end else if (kind < 94) begin
                // pair head marked final ends the map early
                send_word(pair_head(), 1'b1);
            end else begin
                send_word(rand_word(), last_one);
            end
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_entries != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [WORD_W-1:0] base, input logic [SH_W-1:0] sh);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_BASE_OFFSET;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_idx <= CFG_SHIFT_AMOUNT;
        i_cfg_data <= {58'(rand_word()), sh};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [WORD_W-1:0] base, input logic [SH_W-1:0] sh,
                             input int quota, input int in_pct, input int out_pct);
        int first;
        wait_idle();
        set_config(base, sh);
        in_gap_pct = in_pct;
        out_stall_pct = out_pct;
        first = words_sent;
        while (words_sent - first < quota)
            send_map();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_BASE_OFFSET;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_map_word <= '0;
        i_final_word <= 1'b0;
        i_ready <= 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words at the reset settings
        in_gap_pct = 20;
        out_stall_pct = 20;
        send_word(64'h0000_0000_0000_0000, 1'b0);
        send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_word(64'h8000_0000_0000_0000, 1'b0);
        send_word(64'hBFFF_FFFF_FFFF_FFFF, 1'b0);
        send_word(64'h0000_0001_2345_0010, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_word(64'hC000_0000_0000_0000, 1'b0);
        send_word(64'h0000_0000_0000_0000, 1'b0);
        // second words that look like a debug word and like a pair head
        send_word(64'hC000_0012_3400_0042, 1'b0);
        send_word(64'h8000_0000_0000_0005, 1'b0);
        send_word(64'hC000_0000_0100_0001, 1'b0);
        send_word(64'hC123_4567_89AB_CDEF, 1'b0);
        // truncated pair at the end of a map carries the current txg
        send_word(64'h8000_0000_0000_0005, 1'b0);
        send_word(64'hC000_0000_0000_0001, 1'b1);
        send_word(64'h0000_0000_0001_8000, 1'b0);
        send_word(64'h8000_0000_0000_0077, 1'b0);
        send_word(64'h0000_0000_0002_0003, 1'b1);
        send_word(64'h0000_0000_0002_0003, 1'b0);
        send_word(64'hC000_0000_0200_0009, 1'b0);
        send_word(64'h8000_0000_0000_1000, 1'b1);
        send_word(64'h8000_0000_0000_0099, 1'b1);
        send_word(64'h0000_0000_0003_0001, 1'b1);

        run_phase(64'd0, 6'd0, 200, 30, 30);
        run_phase(64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 200, 0, 50);
        run_phase(rand_word(), 6'($urandom), 250, 40, 0);
        run_phase(rand_word(), 6'd1, 200, 15, 15);
        run_phase(rand_word(), 6'd32, 200, 60, 60);
        // closing stretch runs without any idling
        run_phase(rand_word(), 6'($urandom), 250, 0, 0);

        wait_idle();
        if (error_total == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
